// ===== rtl/core/rgb_gradient_max_channel_defines.svh =====
// Assertion macros used by the gradient block's top-level RTL file.
`ifndef RGB_GRADIENT_MAX_CHANNEL_DEFINES_SVH
`define RGB_GRADIENT_MAX_CHANNEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RGBG_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RGBG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rgbg_pkg.sv =====
// Shared constants, types and tables of the RGB gradient block.
package rgbg_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 4096;
  localparam int unsigned DEF_CHANNEL_BITS = 16;

  // Frame geometry limits and register reset values.
  localparam int unsigned ROW_BITS      = 12;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned CFG_DIM_BITS  = 13;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam logic [12:0] RST_WIDTH     = 13'd640;
  localparam logic [12:0] RST_HEIGHT    = 13'd480;

  // Register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Output modes; the unused code behaves as MODE_BOTH.
  localparam logic [1:0] MODE_MAG  = 2'd0;
  localparam logic [1:0] MODE_DIR  = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  // Result field widths.
  localparam int unsigned MAG_BITS = 17;
  localparam int unsigned DIR_BITS = 16;
  localparam logic [31:0] MAG_LIMIT = 32'd131071;

  // CORDIC datapath: x and y after normalization stay below 2^41, the angle is Q2.30.
  localparam int unsigned CORDIC_XW    = 43;
  localparam int unsigned CORDIC_ZW    = 36;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned NORM_BIT     = 38;
  localparam logic signed [CORDIC_ZW-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [CORDIC_ZW-1:0] DIR_LIMIT = 36'sd25736;
  localparam logic signed [CORDIC_ZW-1:0] ROUND_Q13 = 36'sd65536;

  typedef struct packed {
    logic                done;
    logic [MAG_BITS-1:0] mag;
    logic [DIR_BITS-1:0] dir;
  } grad_res_t;

  // Arctangent of 2^-i in Q2.30, rounded to nearest.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:  val = 30'd843314857;
      5'd1:  val = 30'd497837829;
      5'd2:  val = 30'd263043837;
      5'd3:  val = 30'd133525159;
      5'd4:  val = 30'd67021687;
      5'd5:  val = 30'd33543516;
      5'd6:  val = 30'd16775851;
      5'd7:  val = 30'd8388437;
      5'd8:  val = 30'd4194283;
      5'd9:  val = 30'd2097149;
      5'd10: val = 30'd1048576;
      5'd11: val = 30'd524288;
      5'd12: val = 30'd262144;
      5'd13: val = 30'd131072;
      5'd14: val = 30'd65536;
      5'd15: val = 30'd32768;
      5'd16: val = 30'd16384;
      5'd17: val = 30'd8192;
      5'd18: val = 30'd4096;
      5'd19: val = 30'd2048;
      5'd20: val = 30'd1024;
      5'd21: val = 30'd512;
      5'd22: val = 30'd256;
      5'd23: val = 30'd128;
      5'd24: val = 30'd64;
      5'd25: val = 30'd32;
      5'd26: val = 30'd16;
      5'd27: val = 30'd8;
      5'd28: val = 30'd4;
      5'd29: val = 30'd2;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/rgb_gradient_max_channel.sv =====
// Top level of the RGB gradient block: row stores, window, sequencer and result register.
//
// The block takes RGB pixels in raster order and, per pixel, forms central differences
// (left minus right, up minus down, edges clamped) on each channel, keeps the channel
// with the largest squared magnitude and reports its floor square root, its atan2 angle
// in Q2.13 radians, or both, selected by the mode register. A pixel's result appears once
// the pixel below and to its right has arrived; the last row comes out alongside the row
// above it, so one input beat causes zero to four result beats, the final one marked by
// out_tlast. Two row stores live in single-port-read RAMs, so each pixel passes the read
// states ST_RD0 to ST_RD3 and the write-back states ST_WR0 to ST_WR2, plus ST_IDLE to
// accept it and ST_FIN to shift the window. Every result then goes through a shared math
// unit: bitwise square-root steps when the mode asks for a magnitude; normalizing
// shifts and 30 CORDIC steps when it asks for a direction of a nonzero gradient. One pixel
// is worked at a time. A finished result waits in an output register, so the next pixel is
// taken while it waits. Registers may be written only between pixels. Store entries need no
// clearing: every entry is written before it is read during a normal frame.
module rgb_gradient_max_channel #(
  parameter int unsigned MAX_WIDTH    = rgbg_pkg::DEF_MAX_WIDTH,
  parameter int unsigned CHANNEL_BITS = rgbg_pkg::DEF_CHANNEL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red [15:0], green [31:16], blue [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_col [11:0], out_row [23:12], grad_magnitude [40:24], grad_direction [56:41],
  // zeros [63:57]
  output logic [63:0] out_tdata,
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [rgbg_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [rgbg_pkg::CFG_DIM_BITS-1:0] cfg_wdata
);

  `include "rgb_gradient_max_channel_defines.svh"

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned PW = 3 * CB;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = rgbg_pkg::ROW_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RD1  = 4'd2;
  localparam logic [3:0] ST_RD2  = 4'd3;
  localparam logic [3:0] ST_RD3  = 4'd4;
  localparam logic [3:0] ST_WR0  = 4'd5;
  localparam logic [3:0] ST_WR1  = 4'd6;
  localparam logic [3:0] ST_WR2  = 4'd7;
  localparam logic [3:0] ST_NEXT = 4'd8;
  localparam logic [3:0] ST_CALC = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  // Configuration registers.
  logic [1:0]                        mode_r;
  logic [rgbg_pkg::CFG_DIM_BITS-1:0] width_r, height_r;

  // Sequencer and per-pixel context.
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] c_r, p_r, ma_r;
  logic [RW-1:0] r_r;
  logic          last_col_r, row_ge1_r, row_is1_r, c_ge2_r, p_is0_r;
  logic [3:0]    pend_r;
  logic [1:0]    sel_r;
  logic [RW-1:0] res_row_r;
  logic [CW-1:0] res_col_r;
  logic [PW-1:0] cur_r, lw0_r, lw1_r;
  logic [PW-1:0] mid_a_r, mid_p_r, mid_c_r, up_p_r, up_c_r;

  // Result register.
  logic          out_tvalid_r, out_tlast_r;
  logic [63:0]   out_tdata_r;

  // Effective frame geometry and the position of the incoming pixel.
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [CW-1:0] wm1, c_in;
  logic [RW-1:0] hm1, r_in;
  logic          in_acc, out_load, last_flag;
  logic [1:0]    sel_nxt;
  logic [PW-1:0] cur_in;

  // RAM ports.
  logic          mid_we, up_we;
  logic [CW-1:0] mid_waddr, up_waddr, mid_raddr, up_raddr;
  logic [PW-1:0] mid_wdata, up_wdata, mid_q, up_q;

  // Gradient unit operands.
  logic [PW-1:0]       op_lf, op_rt, op_up, op_dn;
  rgbg_pkg::grad_res_t gu_res;

  // Width saturates to [2, MAX_WIDTH], height to [2, 4096].
  always_comb begin
    if (width_r < rgbg_pkg::CFG_DIM_BITS'(2)) begin
      w_eff = WW'(2);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r < 13'd2) begin
      h_eff = 13'd2;
    end else if (32'(height_r) > 32'(rgbg_pkg::MAX_HEIGHT)) begin
      h_eff = 13'(rgbg_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign wm1  = CW'(w_eff - WW'(1));
  assign hm1  = RW'(h_eff - 13'd1);
  // A counter left beyond the frame by a register change saturates to the last position.
  assign c_in = (col_cnt_r > wm1) ? wm1 : col_cnt_r;
  assign r_in = (row_cnt_r > hm1) ? hm1 : row_cnt_r;

  assign cur_in = {CB'(in_tdata[47:32]), CB'(in_tdata[31:16]), CB'(in_tdata[15:0])};

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // Pending results go out in order: lowest index first.
  always_comb begin
    if (pend_r[0]) begin
      sel_nxt = 2'd0;
    end else if (pend_r[1]) begin
      sel_nxt = 2'd1;
    end else if (pend_r[2]) begin
      sel_nxt = 2'd2;
    end else begin
      sel_nxt = 2'd3;
    end
  end

  assign last_flag = ((pend_r & ~(4'b0001 << sel_r)) == 4'b0000);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rgbg_pkg::MODE_MAG;
      width_r  <= rgbg_pkg::RST_WIDTH;
      height_r <= rgbg_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rgbg_pkg::REG_MODE:   mode_r   <= cfg_wdata[1:0];
        rgbg_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        rgbg_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: read the stores, write them back, then emit each pending result.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_WR0;
      ST_WR0:  state_nxt = ST_WR1;
      ST_WR1:  state_nxt = ST_WR2;
      ST_WR2:  state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = (pend_r == 4'b0000) ? ST_FIN : ST_CALC;
      ST_CALC: if (gu_res.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_NEXT;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      pend_r    <= 4'b0000;
      lw0_r     <= '0;
      lw1_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        // Which of the four result positions this pixel completes.
        pend_r[0] <= (c_in != '0) && (r_in != '0);
        pend_r[1] <= (c_in != '0) && (r_in == hm1);
        pend_r[2] <= (c_in == wm1) && (r_in != '0);
        pend_r[3] <= (c_in == wm1) && (r_in == hm1);
        if (c_in == wm1) begin
          col_cnt_r <= '0;
          row_cnt_r <= (r_in == hm1) ? '0 : r_in + RW'(1);
        end else begin
          col_cnt_r <= c_in + CW'(1);
        end
      end
      if (out_load) begin
        pend_r[sel_r] <= 1'b0;
      end
      if (state_r == ST_FIN) begin
        lw1_r <= lw0_r;
        lw0_r <= cur_r;
      end
    end
  end

  // Per-pixel context and captured store words.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r      <= cur_in;
      c_r        <= c_in;
      r_r        <= r_in;
      p_r        <= c_in - CW'(1);
      ma_r       <= (c_in >= CW'(2)) ? c_in - CW'(2) : '0;
      last_col_r <= (c_in == wm1);
      row_ge1_r  <= (r_in != '0);
      row_is1_r  <= (r_in == RW'(1));
      c_ge2_r    <= (c_in >= CW'(2));
      p_is0_r    <= (c_in == CW'(1));
    end
    case (state_r)
      ST_RD1: begin
        mid_a_r <= mid_q;
        up_p_r  <= up_q;
      end
      ST_RD2: begin
        mid_p_r <= mid_q;
        up_c_r  <= up_q;
      end
      ST_RD3:  mid_c_r <= mid_q;
      ST_NEXT: begin
        sel_r     <= sel_nxt;
        res_col_r <= (sel_nxt[1]) ? c_r : p_r;
        res_row_r <= (sel_nxt[0]) ? r_r : r_r - RW'(1);
      end
      default: ;
    endcase
  end

  // Store addressing. Reads go first, so write-back never races a pending read.
  always_comb begin
    mid_raddr = c_r;
    up_raddr  = c_r;
    mid_we    = 1'b0;
    up_we     = 1'b0;
    mid_waddr = c_r;
    up_waddr  = c_r;
    mid_wdata = cur_r;
    up_wdata  = mid_c_r;
    case (state_r)
      ST_RD0: begin
        mid_raddr = ma_r;
        up_raddr  = p_r;
      end
      ST_RD1:  mid_raddr = p_r;
      ST_WR0: begin
        // The pixel two to the left settles into the middle row; its old value moves up.
        mid_we    = c_ge2_r;
        mid_waddr = ma_r;
        mid_wdata = lw1_r;
        up_we     = c_ge2_r && row_ge1_r;
        up_waddr  = ma_r;
        up_wdata  = mid_a_r;
      end
      ST_WR1: begin
        mid_we    = last_col_r;
        mid_waddr = p_r;
        mid_wdata = lw0_r;
        up_we     = last_col_r && row_ge1_r;
        up_waddr  = p_r;
        up_wdata  = mid_p_r;
      end
      ST_WR2: begin
        mid_we = last_col_r;
        up_we  = last_col_r && row_ge1_r;
      end
      default: ;
    endcase
  end

  rgbg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (mid_waddr),
    .wdata (mid_wdata),
    .raddr (mid_raddr),
    .rdata (mid_q)
  );

  rgbg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (up_we),
    .waddr (up_waddr),
    .wdata (up_wdata),
    .raddr (up_raddr),
    .rdata (up_q)
  );

  // Neighbors of each result position. On the second row the row above is clamped to the
  // first row, which still sits in the middle store.
  always_comb begin
    unique case (sel_nxt)
      2'd0: begin
        op_lf = mid_a_r;
        op_rt = mid_c_r;
        op_up = row_is1_r ? mid_p_r : up_p_r;
        op_dn = lw0_r;
      end
      2'd1: begin
        op_lf = p_is0_r ? lw0_r : lw1_r;
        op_rt = cur_r;
        op_up = mid_p_r;
        op_dn = lw0_r;
      end
      2'd2: begin
        op_lf = mid_p_r;
        op_rt = mid_c_r;
        op_up = row_is1_r ? mid_c_r : up_c_r;
        op_dn = cur_r;
      end
      default: begin
        op_lf = lw0_r;
        op_rt = cur_r;
        op_up = mid_c_r;
        op_dn = cur_r;
      end
    endcase
  end

  rgbg_grad_unit #(.CHANNEL_BITS(CHANNEL_BITS)) u_grad (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  ((state_r == ST_NEXT) && (pend_r != 4'b0000)),
    .do_mag (mode_r != rgbg_pkg::MODE_DIR),
    .do_dir (mode_r != rgbg_pkg::MODE_MAG),
    .pix_lf (op_lf),
    .pix_rt (op_rt),
    .pix_up (op_up),
    .pix_dn (op_dn),
    .res    (gu_res)
  );

  // Output register: holds one beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {7'd0, gu_res.dir, gu_res.mag, 12'(res_row_r), 12'(res_col_r)};
      out_tlast_r <= last_flag;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `RGBG_ASSERT_IMPLY(a_pos_in_frame, clk, rst_n, state_r != ST_IDLE, c_r <= wm1, "pixel column beyond frame")
  `RGBG_ASSERT_IMPLY(a_done_in_calc, clk, rst_n, gu_res.done, state_r == ST_CALC, "math result with no request")
  `RGBG_ASSERT_IMPLY(a_write_phase, clk, rst_n, mid_we || up_we, state_r == ST_WR0 || state_r == ST_WR1 || state_r == ST_WR2, "store write outside write-back")
  `RGBG_ASSERT_NEXT(a_last_drains, clk, rst_n, out_load && last_flag, state_r == ST_NEXT && pend_r == 4'b0000, "results left after last beat")

endmodule

// ===== rtl/core/rgbg_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rgbg_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rgbg_grad_unit.sv =====
// Gradient math for one pixel: channel pick, iterative square root and CORDIC angle.
module rgbg_grad_unit #(
  parameter int unsigned CHANNEL_BITS = rgbg_pkg::DEF_CHANNEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      do_mag,
  input  logic                      do_dir,
  input  logic [3*CHANNEL_BITS-1:0] pix_lf,
  input  logic [3*CHANNEL_BITS-1:0] pix_rt,
  input  logic [3*CHANNEL_BITS-1:0] pix_up,
  input  logic [3*CHANNEL_BITS-1:0] pix_dn,
  output rgbg_pkg::grad_res_t       res
);

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned DW  = CB + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned XW  = rgbg_pkg::CORDIC_XW;
  localparam int unsigned ZW  = rgbg_pkg::CORDIC_ZW;

  localparam logic [3:0] G_IDLE  = 4'd0;
  localparam logic [3:0] G_SQ    = 4'd1;
  localparam logic [3:0] G_PICK  = 4'd2;
  localparam logic [3:0] G_SQRT  = 4'd3;
  localparam logic [3:0] G_CINIT = 4'd4;
  localparam logic [3:0] G_NORM  = 4'd5;
  localparam logic [3:0] G_CORD  = 4'd6;
  localparam logic [3:0] G_FIN   = 4'd7;
  localparam logic [3:0] G_DONE  = 4'd8;

  localparam logic [XW-1:0] NORM_TOP = XW'(1) << rgbg_pkg::NORM_BIT;

  logic [3:0]                      state_r, state_nxt;
  logic                            do_mag_r, do_dir_r;
  logic signed [DW-1:0]            dx_r [3];
  logic signed [DW-1:0]            dy_r [3];
  logic [SQW-1:0]                  sq_r [3];
  logic signed [DW-1:0]            bdx_r, bdy_r;
  logic [SQW-1:0]                  v_r, root_r, bit_r;
  logic signed [XW-1:0]            x_r, y_r;
  logic signed [ZW-1:0]            z_r;
  logic [4:0]                      i_r;
  logic [rgbg_pkg::MAG_BITS-1:0]   mag_r;
  logic [rgbg_pkg::DIR_BITS-1:0]   dir_r;

  logic [1:0]                      best;
  logic [SQW:0]                    sq_try;
  logic signed [XW-1:0]            ay, mxy, xs, ys;
  logic signed [ZW-1:0]            atan_z, zq;
  logic [31:0]                     root32;

  always_comb begin
    best = (sq_r[0] > sq_r[1]) ? 2'd0 : 2'd1;
    if (sq_r[2] > sq_r[best]) begin
      best = 2'd2;
    end
  end

  assign sq_try = {1'b0, root_r} + {1'b0, bit_r};
  assign ay     = (y_r < 0) ? -y_r : y_r;
  assign mxy    = (x_r > ay) ? x_r : ay;
  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign atan_z = $signed(ZW'(rgbg_pkg::atan_q30(i_r)));
  assign zq     = (z_r + rgbg_pkg::ROUND_Q13) >>> 17;
  assign root32 = 32'(root_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      G_IDLE:  if (start) state_nxt = G_SQ;
      G_SQ:    state_nxt = G_PICK;
      G_PICK:  state_nxt = do_mag_r ? G_SQRT : G_CINIT;
      G_SQRT:  if (bit_r == '0) state_nxt = G_CINIT;
      G_CINIT: begin
        if (!do_dir_r || (bdx_r == '0 && bdy_r == '0)) begin
          state_nxt = G_DONE;
        end else begin
          state_nxt = G_NORM;
        end
      end
      G_NORM:  if (mxy >= $signed(NORM_TOP)) state_nxt = G_CORD;
      G_CORD:  if (i_r == 5'(rgbg_pkg::CORDIC_STEPS - 1)) state_nxt = G_FIN;
      G_FIN:   state_nxt = G_DONE;
      G_DONE:  state_nxt = G_IDLE;
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_IDLE: begin
        do_mag_r <= do_mag;
        do_dir_r <= do_dir;
        // The previous result stays visible until a new request arrives.
        if (start) begin
          mag_r <= '0;
          dir_r <= '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
          dx_r[ch] <= $signed({1'b0, pix_lf[ch*CB +: CB]}) - $signed({1'b0, pix_rt[ch*CB +: CB]});
          dy_r[ch] <= $signed({1'b0, pix_up[ch*CB +: CB]}) - $signed({1'b0, pix_dn[ch*CB +: CB]});
        end
      end
      G_SQ: begin
        for (int ch = 0; ch < 3; ch++) begin
          sq_r[ch] <= SQW'(dx_r[ch]) * SQW'(dx_r[ch]) +
                      SQW'(dy_r[ch]) * SQW'(dy_r[ch]);
        end
      end
      G_PICK: begin
        bdx_r  <= dx_r[best];
        bdy_r  <= dy_r[best];
        v_r    <= sq_r[best];
        root_r <= '0;
        bit_r  <= SQW'(1) << (SQW - 2);
      end
      G_SQRT: begin
        if (bit_r == '0) begin
          mag_r <= (root32 > rgbg_pkg::MAG_LIMIT) ? rgbg_pkg::MAG_BITS'(rgbg_pkg::MAG_LIMIT)
                                                  : rgbg_pkg::MAG_BITS'(root32);
        end else begin
          if ({1'b0, v_r} >= sq_try) begin
            v_r    <= v_r - SQW'(sq_try);
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      G_CINIT: begin
        // Reflect the left half-plane onto the right one and start from +-pi.
        if (bdx_r < 0) begin
          x_r <= -XW'(bdx_r);
          y_r <= -XW'(bdy_r);
          z_r <= (bdy_r >= 0) ? rgbg_pkg::PI_Q30 : -rgbg_pkg::PI_Q30;
        end else begin
          x_r <= XW'(bdx_r);
          y_r <= XW'(bdy_r);
          z_r <= '0;
        end
        i_r <= '0;
      end
      G_NORM: begin
        if (mxy < $signed(NORM_TOP)) begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
        end
      end
      G_CORD: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_z;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_z;
        end
        i_r <= i_r + 5'd1;
      end
      G_FIN: begin
        if (zq > rgbg_pkg::DIR_LIMIT) begin
          dir_r <= rgbg_pkg::DIR_BITS'(rgbg_pkg::DIR_LIMIT);
        end else if (zq < -rgbg_pkg::DIR_LIMIT) begin
          dir_r <= rgbg_pkg::DIR_BITS'(-rgbg_pkg::DIR_LIMIT);
        end else begin
          dir_r <= rgbg_pkg::DIR_BITS'(zq);
        end
      end
      default: ;
    endcase
  end

  assign res.done = (state_r == G_DONE);
  assign res.mag  = mag_r;
  assign res.dir  = dir_r;

endmodule

// ===== tb/sv/rgb_gradient_max_channel_test.sv =====
// Self-checking testbench for the RGB gradient block: raster frames in, predicted results out.
`timescale 1ns / 1ps

module rgb_gradient_max_channel_test;

  // The spare mode code; the block treats it as magnitude plus direction.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int IDLE_PCT   = 19;
  localparam int HOLD_BEATS = 400;    // long receiver hold-off, in cycles
  localparam int SETTLE     = 200;    // covers one pixel still in flight with no result
  localparam int WATCHDOG   = 4000;   // cycles without any handshake
  localparam int STORE_LEN  = 4096;

  localparam int KIND_RANDOM  = 0;
  localparam int KIND_EXTREME = 1;
  localparam int KIND_RAMP    = 2;

  // One pixel, red in element 0 so that it packs like in_tdata.
  typedef logic [2:0][15:0] px_t;

  typedef struct {
    logic [47:0] rgb;
    bit          drain;   // hold this beat back until every result has come
  } pixel_beat_t;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [16:0] mag;
    logic [15:0] dir;
    logic        last;
  } grad_expect_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;   // red [15:0], green [31:16], blue [47:32]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // out_col [11:0], out_row [23:12], grad_magnitude [40:24], grad_direction [56:41],
  // zeros [63:57]
  logic [63:0] out_tdata;
  logic        out_tlast;          // last_of_run
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_addr    = '0;
  logic [12:0] cfg_wdata   = '0;

  rgb_gradient_max_channel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Stimulus and expectation stores.
  pixel_beat_t  pixel_q[$];
  grad_expect_t grad_q[$];
  int           err_cnt     = 0;
  int           pixels_sent = 0;
  int           pixels_in   = 0;
  bit           no_idle     = 1'b0;

  // Predictor copy of the registers and of the block's state.
  logic [1:0]  mdl_mode   = rgbg_pkg::MODE_MAG;
  logic [12:0] mdl_width  = 13'd640;
  logic [12:0] mdl_height = 13'd480;
  px_t         up_st  [STORE_LEN];
  px_t         mid_st [STORE_LEN];
  px_t         lw     [2] = '{default: '0};
  int          col_cnt = 0;
  int          row_cnt = 0;

  // Arctangent of 2^-i in Q2.30, rounded to nearest.
  localparam longint ATAN_TAB [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint DIR_MAX = 25736;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor square root, built one result bit at a time from the top.
  function automatic int floor_sqrt(input longint v);
    longint root;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= v) begin
        root = root | (64'd1 << b);
      end
    end
    return int'(root);
  endfunction

  // Vectoring CORDIC: the angle of (dx, dy) in Q2.30, rounded to Q2.13 and clamped.
  function automatic longint cordic_angle(input longint dx, input longint dy);
    longint x, y, z, xs, ys, m, q;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) begin
      return 0;
    end
    // Fold the left half-plane over, starting from plus or minus pi.
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    m = (x > ((y < 0) ? -y : y)) ? x : ((y < 0) ? -y : y);
    while (m < (64'sd1 <<< 38)) begin
      m = m * 2;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    q = (z + 65536) >>> 17;
    if (q > DIR_MAX) q = DIR_MAX;
    if (q < -DIR_MAX) q = -DIR_MAX;
    return q;
  endfunction

  // Gradient of one result pixel from its four neighbors; the strongest channel wins,
  // a tie between channels 0 and 1 goes to channel 1, and channel 2 wins only when strictly stronger.
  function automatic grad_expect_t pixel_gradient(input int col, input int row,
                                                  input px_t lf, input px_t rt,
                                                  input px_t up, input px_t dn);
    longint       dx [3];
    longint       dy [3];
    longint       sq [3];
    int           best;
    grad_expect_t g;
    for (int ch = 0; ch < 3; ch++) begin
      dx[ch] = longint'(lf[ch]) - longint'(rt[ch]);
      dy[ch] = longint'(up[ch]) - longint'(dn[ch]);
      sq[ch] = dx[ch] * dx[ch] + dy[ch] * dy[ch];
    end
    best = (sq[0] > sq[1]) ? 0 : 1;
    if (sq[2] > sq[best]) best = 2;
    g.col  = col[11:0];
    g.row  = row[11:0];
    g.mag  = (mdl_mode != rgbg_pkg::MODE_DIR) ? 17'(floor_sqrt(sq[best])) : '0;
    g.dir  = (mdl_mode != rgbg_pkg::MODE_MAG) ? 16'(cordic_angle(dx[best], dy[best])) : '0;
    g.last = 1'b0;
    return g;
  endfunction

  // Works out the results caused by one accepted pixel and advances the window state.
  task automatic predict_pixel(input logic [47:0] data);
    int           w, h, c, r, p;
    px_t          cur;
    grad_expect_t res[$];
    cur = px_t'(data);
    w = mdl_width;
    h = mdl_height;
    if (w < 2) w = 2;
    if (w > STORE_LEN) w = STORE_LEN;
    if (h < 2) h = 2;
    if (h > 4096) h = 4096;
    c = (col_cnt > w - 1) ? w - 1 : col_cnt;
    r = (row_cnt > h - 1) ? h - 1 : row_cnt;

    // The pixel up and to the left is now complete; on the last row so is its neighbor.
    if (c >= 1) begin
      p = c - 1;
      if (r >= 1) begin
        res.push_back(pixel_gradient(p, r - 1, mid_st[(p == 0) ? 0 : p - 1], mid_st[c],
                                     (r == 1) ? mid_st[p] : up_st[p], lw[0]));
      end
      if (r == h - 1) begin
        res.push_back(pixel_gradient(p, r, (p == 0) ? lw[0] : lw[1], cur, mid_st[p],
                                     lw[0]));
      end
    end
    // The right edge column is flushed when the row ends.
    if (c == w - 1) begin
      if (r >= 1) begin
        res.push_back(pixel_gradient(w - 1, r - 1, mid_st[w - 2], mid_st[w - 1],
                                     (r == 1) ? mid_st[w - 1] : up_st[w - 1], cur));
      end
      if (r == h - 1) begin
        res.push_back(pixel_gradient(w - 1, r, lw[0], cur, mid_st[w - 1], cur));
      end
    end

    // Row stores trail the window by two columns.
    if (c >= 2) begin
      if (r >= 1) up_st[c - 2] = mid_st[c - 2];
      mid_st[c - 2] = lw[1];
    end
    if (c == w - 1) begin
      if (r >= 1) begin
        up_st[w - 2] = mid_st[w - 2];
        up_st[w - 1] = mid_st[w - 1];
      end
      mid_st[w - 2] = lw[0];
      mid_st[w - 1] = cur;
    end
    lw[1] = lw[0];
    lw[0] = cur;

    if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end

    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) grad_q.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Input side: a beat may change only when the previous one was taken.
  always @(posedge clk) begin
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (pixel_q.size() != 0 &&
          !(pixel_q[0].drain && (in_tvalid || grad_q.size() != 0)) &&
          (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_q[0].rgb;
        void'(pixel_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted pixel feeds the predictor at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_pixel(in_tdata);
      pixels_in++;
    end
  end

  // Result side: random stalls, plus one long hold-off once the random frames are under
  // way so that the block backs up and stops taking pixels.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && pixels_in >= 60) begin
        hold_left = HOLD_BEATS;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    grad_expect_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (grad_q.size() == 0) begin
        report_mismatch("unexpected result beat, column", out_tdata[11:0], -1);
      end else begin
        e = grad_q.pop_front();
        if (out_tdata[11:0] !== e.col) report_mismatch("out_col", out_tdata[11:0], e.col);
        if (out_tdata[23:12] !== e.row) report_mismatch("out_row", out_tdata[23:12], e.row);
        if (out_tdata[40:24] !== e.mag) begin
          report_mismatch("grad_magnitude", out_tdata[40:24], e.mag);
        end
        if (out_tdata[56:41] !== e.dir) begin
          report_mismatch("grad_direction", $signed(out_tdata[56:41]), $signed(e.dir));
        end
        if (out_tdata[63:57] !== 7'd0) report_mismatch("padding", out_tdata[63:57], 0);
        if (out_tlast !== e.last) report_mismatch("out_tlast", out_tlast, e.last);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      rgbg_pkg::REG_MODE:   mdl_mode   = val[1:0];
      rgbg_pkg::REG_WIDTH:  mdl_width  = val;
      rgbg_pkg::REG_HEIGHT: mdl_height = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_frame(input logic [1:0] mode, input logic [12:0] w,
                             input logic [12:0] h);
    write_reg(rgbg_pkg::REG_MODE, {11'd0, mode});
    write_reg(rgbg_pkg::REG_WIDTH, w);
    write_reg(rgbg_pkg::REG_HEIGHT, h);
  endtask

  // Waits until the block has nothing left to do, then lets a pixel with no result settle.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_tvalid || grad_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic px_t make_pixel(input int kind, input int col);
    px_t px;
    for (int ch = 0; ch < 3; ch++) begin
      case (kind)
        KIND_EXTREME: px[ch] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        // Equal channels rising to the right: dx is negative, dy is zero, channels tie.
        KIND_RAMP:    px[ch] = 16'(col * 8000);
        default:      px[ch] = ($urandom_range(3) == 0) ?
                               ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      endcase
    end
    return px;
  endfunction

  // Queues one whole frame; drain_at marks the beat that waits for all results, or -1.
  task automatic push_frame(input int w, input int h, input int kind, input int drain_at);
    pixel_beat_t b;
    for (int i = 0; i < w * h; i++) begin
      b.rgb   = make_pixel(kind, i % w);
      b.drain = (i == drain_at);
      pixel_q.push_back(b);
      pixels_sent++;
    end
  endtask

  initial begin
    int w, h, frame_no;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: smallest frame, all-or-nothing channels, every mode code,
    // out-of-range sizes that saturate to the minimum, and a ramp that points to pi.
    setup_frame(rgbg_pkg::MODE_MAG, 13'd2, 13'd2);
    push_frame(2, 2, KIND_EXTREME, -1);
    wait_idle();
    setup_frame(rgbg_pkg::MODE_DIR, 13'd3, 13'd3);
    push_frame(3, 3, KIND_EXTREME, -1);
    wait_idle();
    setup_frame(MODE_SPARE, 13'd1, 13'd0);
    push_frame(2, 2, KIND_EXTREME, -1);
    wait_idle();
    setup_frame(rgbg_pkg::MODE_BOTH, 13'd4, 13'd2);
    push_frame(4, 2, KIND_RAMP, -1);
    wait_idle();

    // The largest sizes are written too, then replaced before any pixel flows.
    setup_frame(rgbg_pkg::MODE_BOTH, 13'd4096, 13'd4096);

    // Random frames, mostly small; one pauses mid-frame, the next runs without idling.
    frame_no = 0;
    while (pixels_sent < 110) begin
      w = $urandom_range(9, 2);
      h = $urandom_range(6, 2);
      setup_frame(2'($urandom_range(3)), 13'(w), 13'(h));
      no_idle = (frame_no == 1);
      push_frame(w, h, ($urandom_range(4) == 0) ? KIND_EXTREME : KIND_RANDOM,
                 (frame_no == 0) ? (w * h) / 2 : -1);
      wait_idle();
      no_idle = 1'b0;
      frame_no++;
    end

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
